// ----- rtl/voxel_face_cull_mesher_top_macros.svh -----
// Assertion macros for the voxel face-cull mesher checker.
// No dependencies; included by files that carry assertions.
`ifndef VOXEL_FACE_CULL_MESHER_TOP_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define VFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vfc_pkg.sv -----
// Shared constants, command/status types and lookup functions for the mesher.
// No dependencies; imported by vfc_ctrl, vfc_dpath, the top level and the checker.
package vfc_pkg;

    localparam int CHUNK_WIDTH = 16;
    localparam int CHUNK_TALL  = 128;
    localparam int SPAN        = CHUNK_WIDTH + 2;
    localparam int DEPTH       = SPAN * CHUNK_TALL * SPAN;
    localparam int AW          = $clog2(DEPTH);

    localparam int XW     = 5;
    localparam int YW     = 7;
    localparam int FXW    = 4;
    localparam int ID_W   = 8;
    localparam int LT_W   = 8;
    localparam int MW     = ID_W + LT_W;
    localparam int DIR_W  = 3;
    localparam int OCC_W  = 2;
    localparam int CFG_IW = 2;

    localparam int NDIR  = 6;
    localparam int NREAD = 15;
    localparam int RIW   = $clog2(NREAD);

    localparam logic [ID_W-1:0] ID_AIR     = 8'h00;
    localparam logic [LT_W-1:0] LIGHT_OPEN = 8'hFF;
    localparam logic [ID_W-1:0] TR_A_RST   = 8'd6;
    localparam logic [ID_W-1:0] TR_B_RST   = 8'd8;
    localparam logic [ID_W-1:0] TR_C_RST   = 8'd13;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_TR_A = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TR_B = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TR_C = 2'd2;

    localparam logic [DIR_W-1:0] DIR_PY = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd2;
    localparam logic [DIR_W-1:0] DIR_PX = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

    // read slots: self, six face neighbors, eight cells above for occlusion
    localparam logic [RIW-1:0] SL_SELF = 4'd0;
    localparam logic [RIW-1:0] SL_XM   = 4'd7;
    localparam logic [RIW-1:0] SL_XP   = 4'd8;
    localparam logic [RIW-1:0] SL_ZM   = 4'd9;
    localparam logic [RIW-1:0] SL_ZP   = 4'd10;
    localparam logic [RIW-1:0] SL_MM   = 4'd11;
    localparam logic [RIW-1:0] SL_PM   = 4'd12;
    localparam logic [RIW-1:0] SL_PP   = 4'd13;
    localparam logic [RIW-1:0] SL_MP   = 4'd14;

    typedef struct packed {
        logic           clear_wr;
        logic           item_wr;
        logic           load;
        logic           rd_issue;
        logic [RIW-1:0] rd_idx;
        logic           emit;
    } t_cmd;

    typedef struct packed {
        logic mesh_ok;
        logic write_ok;
        logic clear_end;
        logic any_left;
        logic last_face;
    } t_stat;

    function automatic logic [1:0] rd_dx(input logic [RIW-1:0] k);
        case (k)
            4'd3, 4'd7, 4'd11, 4'd14: rd_dx = 2'b11;
            4'd4, 4'd8, 4'd12, 4'd13: rd_dx = 2'b01;
            default:                  rd_dx = 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] rd_dy(input logic [RIW-1:0] k);
        case (k)
            4'd1, 4'd7, 4'd8, 4'd9, 4'd10,
            4'd11, 4'd12, 4'd13, 4'd14: rd_dy = 2'b01;
            4'd2:                       rd_dy = 2'b11;
            default:                    rd_dy = 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] rd_dz(input logic [RIW-1:0] k);
        case (k)
            4'd5, 4'd10, 4'd13, 4'd14: rd_dz = 2'b01;
            4'd6, 4'd9, 4'd11, 4'd12:  rd_dz = 2'b11;
            default:                   rd_dz = 2'b00;
        endcase
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y,
                                                input logic [XW-1:0] z);
        logic [AW-1:0] col;
        col = AW'(x) * AW'(CHUNK_TALL) + AW'(y);
        return col * AW'(SPAN) + AW'(z);
    endfunction

    function automatic logic [OCC_W-1:0] occl_level(input logic s1, input logic s2,
                                                    input logic c);
        if (s1 && s2) begin
            return 2'd3;
        end
        return OCC_W'(s1) + OCC_W'(s2) + OCC_W'(c);
    endfunction

endpackage

// ----- rtl/vfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/vfc_ctrl.sv -----
// Mesher controller: clearing pass, neighbor read sequence and face emission.
// Depends on vfc_pkg.
module vfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_operation,
    input  vfc_pkg::t_stat i_stat,
    output vfc_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import vfc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]     r_state, n_state;
    logic [RIW-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.rd_idx = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_MESH && i_stat.mesh_ok) begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = S_READ;
                    end else if (i_operation == OP_WRITE && i_stat.write_ok) begin
                        o_cmd.item_wr = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_end) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (r_step == RIW'(NREAD - 1)) begin
                    n_state = S_TAIL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_TAIL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.any_left) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_face) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ----- rtl/vfc_dpath.sv -----
// Mesher datapath: voxel memory, neighbor capture, culling, occlusion, outputs.
// Depends on vfc_pkg and vfc_ram.
module vfc_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vfc_pkg::t_cmd               i_cmd,
    output vfc_pkg::t_stat              o_stat,
    input  logic                        i_cfg_valid,
    input  logic [vfc_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [vfc_pkg::ID_W-1:0]    i_cfg_data,
    input  logic [vfc_pkg::XW-1:0]      i_cell_x,
    input  logic [vfc_pkg::YW-1:0]      i_cell_y,
    input  logic [vfc_pkg::XW-1:0]      i_cell_z,
    input  logic [vfc_pkg::ID_W-1:0]    i_block_id,
    input  logic [vfc_pkg::LT_W-1:0]    i_light_in,
    output logic                        o_result_valid,
    output logic [vfc_pkg::FXW-1:0]     o_face_x,
    output logic [vfc_pkg::YW-1:0]      o_face_y,
    output logic [vfc_pkg::FXW-1:0]     o_face_z,
    output logic [vfc_pkg::DIR_W-1:0]   o_face_dir,
    output logic [vfc_pkg::ID_W-1:0]    o_material,
    output logic [vfc_pkg::LT_W-1:0]    o_light_level,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mm,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pm,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pp,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mp,
    output logic                        o_last
);
    import vfc_pkg::*;

    logic [ID_W-1:0]  r_tr_a, r_tr_b, r_tr_c;
    logic [XW-1:0]    r_x, r_z;
    logic [YW-1:0]    r_y;
    logic [AW-1:0]    r_clr_addr;
    logic             r_rd_vld, r_rd_in, r_rd_lit;
    logic [RIW-1:0]   r_rd_idx;
    logic [ID_W-1:0]  r_nb_id [NREAD];
    logic [LT_W-1:0]  r_nb_lt [NDIR];
    logic [NDIR-1:0]  r_sent;

    logic             r_result_valid, r_last;
    logic [FXW-1:0]   r_face_x, r_face_z;
    logic [YW-1:0]    r_face_y;
    logic [DIR_W-1:0] r_face_dir;
    logic [ID_W-1:0]  r_material;
    logic [LT_W-1:0]  r_light;
    logic [OCC_W-1:0] r_oc_mm, r_oc_pm, r_oc_pp, r_oc_mp;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [MW-1:0]    ram_wdata, ram_rdata;

    logic [1:0]       dx, dy, dz;
    logic [XW-1:0]    nx, nz;
    logic [YW:0]      ny;
    logic             rd_in, rd_lit;
    logic [DIR_W-1:0] lt_idx;

    logic [ID_W-1:0]  self_id;
    logic [NDIR-1:0]  vis, remaining, sel_oh;
    logic [DIR_W-1:0] sel;
    logic [XW-1:0]    xm1, zm1;
    logic [OCC_W-1:0] oc_mm, oc_pm, oc_pp, oc_mp;
    logic             s_xm, s_xp, s_zm, s_zp;

    vfc_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = i_cmd.clear_wr || i_cmd.item_wr;
    assign ram_waddr = i_cmd.clear_wr ? r_clr_addr : cell_addr(i_cell_x, i_cell_y, i_cell_z);
    assign ram_wdata = i_cmd.clear_wr ? {ID_AIR, LIGHT_OPEN} : {i_block_id, i_light_in};

    assign dx     = rd_dx(i_cmd.rd_idx);
    assign dy     = rd_dy(i_cmd.rd_idx);
    assign dz     = rd_dz(i_cmd.rd_idx);
    assign nx     = r_x + {{(XW-2){dx[1]}}, dx};
    assign nz     = r_z + {{(XW-2){dz[1]}}, dz};
    assign ny     = {1'b0, r_y} + {{(YW-1){dy[1]}}, dy};
    assign rd_in  = (ny < (YW+1)'(CHUNK_TALL));
    assign rd_lit = rd_in && (nx != '0) && (nx != XW'(SPAN - 1))
                    && (nz != '0) && (nz != XW'(SPAN - 1));
    assign ram_raddr = rd_in ? cell_addr(nx, ny[YW-1:0], nz) : '0;
    assign lt_idx    = DIR_W'(r_rd_idx - 1'b1);

    assign o_stat.mesh_ok   = (i_cell_x != '0) && (i_cell_x <= XW'(CHUNK_WIDTH))
                              && (i_cell_z != '0) && (i_cell_z <= XW'(CHUNK_WIDTH))
                              && ({1'b0, i_cell_y} < (YW+1)'(CHUNK_TALL));
    assign o_stat.write_ok  = (i_cell_x < XW'(SPAN)) && (i_cell_z < XW'(SPAN))
                              && ({1'b0, i_cell_y} < (YW+1)'(CHUNK_TALL));
    assign o_stat.clear_end = (r_clr_addr == AW'(DEPTH - 1));

    assign self_id = r_nb_id[SL_SELF];

    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            vis[d] = (self_id != ID_AIR)
                     && ((r_nb_id[d+1] == ID_AIR)
                         || ((r_nb_id[d+1] != self_id)
                             && ((r_nb_id[d+1] == r_tr_a) || (r_nb_id[d+1] == r_tr_b)
                                 || (r_nb_id[d+1] == r_tr_c))));
        end
    end

    assign remaining = vis & ~r_sent;

    always_comb begin
        sel = '0;
        for (int d = NDIR - 1; d >= 0; d--) begin
            if (remaining[d]) begin
                sel = DIR_W'(d);
            end
        end
    end

    assign sel_oh           = NDIR'(1) << sel;
    assign o_stat.any_left  = |remaining;
    assign o_stat.last_face = ((remaining & ~sel_oh) == '0);

    assign s_xm  = (r_nb_id[SL_XM] != ID_AIR);
    assign s_xp  = (r_nb_id[SL_XP] != ID_AIR);
    assign s_zm  = (r_nb_id[SL_ZM] != ID_AIR);
    assign s_zp  = (r_nb_id[SL_ZP] != ID_AIR);
    assign oc_mm = occl_level(s_xm, s_zm, r_nb_id[SL_MM] != ID_AIR);
    assign oc_pm = occl_level(s_xp, s_zm, r_nb_id[SL_PM] != ID_AIR);
    assign oc_pp = occl_level(s_xp, s_zp, r_nb_id[SL_PP] != ID_AIR);
    assign oc_mp = occl_level(s_xm, s_zp, r_nb_id[SL_MP] != ID_AIR);
    assign xm1   = r_x - 1'b1;
    assign zm1   = r_z - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_a         <= TR_A_RST;
            r_tr_b         <= TR_B_RST;
            r_tr_c         <= TR_C_RST;
            r_clr_addr     <= '0;
            r_rd_vld       <= 1'b0;
            r_sent         <= '0;
            r_result_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TR_A: r_tr_a <= i_cfg_data;
                    CFG_TR_B: r_tr_b <= i_cfg_data;
                    CFG_TR_C: r_tr_c <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.load) begin
                r_sent <= '0;
            end else if (i_cmd.emit) begin
                r_sent <= r_sent | sel_oh;
            end
            r_result_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_cell_x;
            r_y <= i_cell_y;
            r_z <= i_cell_z;
        end
        r_rd_idx <= i_cmd.rd_idx;
        r_rd_in  <= rd_in;
        r_rd_lit <= rd_lit;
        if (r_rd_vld) begin
            r_nb_id[r_rd_idx] <= r_rd_in ? ram_rdata[MW-1:LT_W] : ID_AIR;
            if (r_rd_idx != SL_SELF && r_rd_idx <= RIW'(NDIR)) begin
                r_nb_lt[lt_idx] <= r_rd_lit ? ram_rdata[LT_W-1:0] : LIGHT_OPEN;
            end
        end
        if (i_cmd.emit) begin
            r_face_x   <= xm1[FXW-1:0];
            r_face_y   <= r_y;
            r_face_z   <= zm1[FXW-1:0];
            r_face_dir <= sel;
            r_material <= self_id;
            r_light    <= r_nb_lt[sel];
            r_last     <= o_stat.last_face;
            if (sel == DIR_PY) begin
                r_oc_mm <= oc_mm;
                r_oc_pm <= oc_pm;
                r_oc_pp <= oc_pp;
                r_oc_mp <= oc_mp;
            end else begin
                r_oc_mm <= '0;
                r_oc_pm <= '0;
                r_oc_pp <= '0;
                r_oc_mp <= '0;
            end
        end
    end

    assign o_result_valid   = r_result_valid;
    assign o_face_x         = r_face_x;
    assign o_face_y         = r_face_y;
    assign o_face_z         = r_face_z;
    assign o_face_dir       = r_face_dir;
    assign o_material       = r_material;
    assign o_light_level    = r_light;
    assign o_occl_corner_mm = r_oc_mm;
    assign o_occl_corner_pm = r_oc_pm;
    assign o_occl_corner_pp = r_oc_pp;
    assign o_occl_corner_mp = r_oc_mp;
    assign o_last           = r_last;
endmodule

// ----- rtl/voxel_face_cull_mesher_top.sv -----
// Mesh item: 15 voxel-memory reads (one per cycle, single read port), a settle
// state (S_TAIL), then one face per cycle; busy stays high through the read, settle
// and emit states. Write item: busy stays low.
// Results appear for one cycle on o_result_valid; the receiver cannot stall.
// Synchronous active-low reset; a clearing pass over all 41472 cells follows with busy high.
// Top level of the voxel face-cull mesher; depends on vfc_pkg, vfc_ctrl, vfc_dpath.
module voxel_face_cull_mesher_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [vfc_pkg::XW-1:0]      i_cell_x,
    input  logic [vfc_pkg::YW-1:0]      i_cell_y,
    input  logic [vfc_pkg::XW-1:0]      i_cell_z,
    input  logic [vfc_pkg::ID_W-1:0]    i_block_id,
    input  logic [vfc_pkg::LT_W-1:0]    i_light_in,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vfc_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [vfc_pkg::ID_W-1:0]    i_cfg_data,
    output logic                        o_result_valid,
    output logic [vfc_pkg::FXW-1:0]     o_face_x,
    output logic [vfc_pkg::YW-1:0]      o_face_y,
    output logic [vfc_pkg::FXW-1:0]     o_face_z,
    output logic [vfc_pkg::DIR_W-1:0]   o_face_dir,
    output logic [vfc_pkg::ID_W-1:0]    o_material,
    output logic [vfc_pkg::LT_W-1:0]    o_light_level,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mm,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pm,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pp,
    output logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mp,
    output logic                        o_last
);
    import vfc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    vfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    vfc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_cell_z         (i_cell_z),
        .i_block_id       (i_block_id),
        .i_light_in       (i_light_in),
        .o_result_valid   (o_result_valid),
        .o_face_x         (o_face_x),
        .o_face_y         (o_face_y),
        .o_face_z         (o_face_z),
        .o_face_dir       (o_face_dir),
        .o_material       (o_material),
        .o_light_level    (o_light_level),
        .o_occl_corner_mm (o_occl_corner_mm),
        .o_occl_corner_pm (o_occl_corner_pm),
        .o_occl_corner_pp (o_occl_corner_pp),
        .o_occl_corner_mp (o_occl_corner_mp),
        .o_last           (o_last)
    );
endmodule

// ----- rtl/vfc_checker.sv -----
// Port-level checker for the mesher top level, bound in below.
// Depends on vfc_pkg and voxel_face_cull_mesher_top_macros.svh.
`include "voxel_face_cull_mesher_top_macros.svh"

module vfc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic [vfc_pkg::DIR_W-1:0]   o_face_dir,
    input logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mm,
    input logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pm,
    input logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_pp,
    input logic [vfc_pkg::OCC_W-1:0]   o_occl_corner_mp,
    input logic                        o_last
);
    import vfc_pkg::*;

    `VFC_ASSERT_NOW(a_beat_after_busy, i_clk, i_rst_n, o_result_valid, $past(busy), "result beat without a busy cycle before it")
    `VFC_ASSERT_NEXT(a_no_beat_after_accept, i_clk, i_rst_n, start && !busy, !o_result_valid, "result beat right after accept")
    `VFC_ASSERT_NOW(a_occl_top_only, i_clk, i_rst_n, o_result_valid && o_face_dir != DIR_PY, o_occl_corner_mm == '0 && o_occl_corner_pm == '0 && o_occl_corner_pp == '0 && o_occl_corner_mp == '0, "occlusion on a side face")
    `VFC_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_result_valid && o_last, !o_result_valid, "result beat right after last")
endmodule

bind voxel_face_cull_mesher_top vfc_checker u_vfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_face_dir       (o_face_dir),
    .o_occl_corner_mm (o_occl_corner_mm),
    .o_occl_corner_pm (o_occl_corner_pm),
    .o_occl_corner_pp (o_occl_corner_pp),
    .o_occl_corner_mp (o_occl_corner_mp),
    .o_last           (o_last)
);

// ----- tb/voxel_face_cull_mesher_top_tb.sv -----
// Self-checking testbench for voxel_face_cull_mesher_top: a directed table, then random
// window-filling write bursts followed by mesh commands, checked beat by beat against a predictor.
// Depends on vfc_pkg and voxel_face_cull_mesher_top.
module voxel_face_cull_mesher_top_tb;
    import vfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BARE} t_check;

    typedef struct packed {
        logic              op;
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [XW-1:0]     z;
        logic [ID_W-1:0]   id;
        logic [LT_W-1:0]   li;
    } t_cell_cmd;

    typedef struct {
        t_cell_cmd cmd;
        t_check    chk;
    } t_plan_row;

    typedef struct packed {
        logic [FXW-1:0]   fx;
        logic [YW-1:0]    fy;
        logic [FXW-1:0]   fz;
        logic [DIR_W-1:0] dir;
        logic [ID_W-1:0]  mat;
        logic [LT_W-1:0]  lt;
        logic [OCC_W-1:0] mm;
        logic [OCC_W-1:0] pm;
        logic [OCC_W-1:0] pp;
        logic [OCC_W-1:0] mp;
        logic             last;
    } t_face;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_operation = OP_WRITE;
    logic [XW-1:0]       i_cell_x = '0;
    logic [YW-1:0]       i_cell_y = '0;
    logic [XW-1:0]       i_cell_z = '0;
    logic [ID_W-1:0]     i_block_id = '0;
    logic [LT_W-1:0]     i_light_in = '0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [ID_W-1:0]     i_cfg_data = '0;
    logic                o_result_valid;
    logic [FXW-1:0]      o_face_x;
    logic [YW-1:0]       o_face_y;
    logic [FXW-1:0]      o_face_z;
    logic [DIR_W-1:0]    o_face_dir;
    logic [ID_W-1:0]     o_material;
    logic [LT_W-1:0]     o_light_level;
    logic [OCC_W-1:0]    o_occl_corner_mm;
    logic [OCC_W-1:0]    o_occl_corner_pm;
    logic [OCC_W-1:0]    o_occl_corner_pp;
    logic [OCC_W-1:0]    o_occl_corner_mp;
    logic                o_last;

    logic [ID_W-1:0] id_mem    [0:SPAN-1][0:CHUNK_TALL-1][0:SPAN-1];
    logic [LT_W-1:0] light_mem [0:SPAN-1][0:CHUNK_TALL-1][0:SPAN-1];
    logic [ID_W-1:0] see_a, see_b, see_c;

    t_face     pending_faces[$];
    t_plan_row plan[$];
    int        face_errs = 0;
    int        cycle_count = 0;

    voxel_face_cull_mesher_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_cell_z         (i_cell_z),
        .i_block_id       (i_block_id),
        .i_light_in       (i_light_in),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_face_x         (o_face_x),
        .o_face_y         (o_face_y),
        .o_face_z         (o_face_z),
        .o_face_dir       (o_face_dir),
        .o_material       (o_material),
        .o_light_level    (o_light_level),
        .o_occl_corner_mm (o_occl_corner_mm),
        .o_occl_corner_pm (o_occl_corner_pm),
        .o_occl_corner_pp (o_occl_corner_pp),
        .o_occl_corner_mp (o_occl_corner_mp),
        .o_last           (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("voxel_face_cull_mesher_top_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] id_of(input int x, input int y, input int z);
        if (y < 0 || y >= CHUNK_TALL || x < 0 || x >= SPAN || z < 0 || z >= SPAN) begin
            return ID_AIR;
        end
        return id_mem[x][y][z];
    endfunction

    function automatic logic [LT_W-1:0] light_of(input int x, input int y, input int z);
        if (y < 0 || y >= CHUNK_TALL) begin
            return LIGHT_OPEN;
        end
        if (x < 1 || x > CHUNK_WIDTH || z < 1 || z > CHUNK_WIDTH) begin
            return LIGHT_OPEN;
        end
        return light_mem[x][y][z];
    endfunction

    function automatic logic see_through(input logic [ID_W-1:0] self, input logic [ID_W-1:0] nb);
        if (nb == ID_AIR) begin
            return 1'b1;
        end
        if (nb == self) begin
            return 1'b0;
        end
        return nb == see_a || nb == see_b || nb == see_c;
    endfunction

    function automatic logic [OCC_W-1:0] shade(input logic [ID_W-1:0] s1,
                                               input logic [ID_W-1:0] s2,
                                               input logic [ID_W-1:0] c);
        int n;
        n = int'(s1 != ID_AIR) + int'(s2 != ID_AIR) + int'(c != ID_AIR);
        if (s1 != ID_AIR && s2 != ID_AIR) begin
            n = 3;
        end
        return OCC_W'(n);
    endfunction

    function automatic string face_str(input t_face f);
        return $sformatf("x=%0d y=%0d z=%0d dir=%0d mat=%0d light=%0d ao=%0d/%0d/%0d/%0d last=%0d",
                         f.fx, f.fy, f.fz, f.dir, f.mat, f.lt, f.mm, f.pm, f.pp, f.mp, f.last);
    endfunction

    task automatic predict_faces(input t_cell_cmd c);
        int x, y, z, nx, ny, nz, t, d;
        logic [ID_W-1:0] self, xm, xp, zm, zp;
        t_face f;
        t_face found[$];
        x = c.x;
        y = c.y;
        z = c.z;
        if (x < 1 || x > CHUNK_WIDTH || z < 1 || z > CHUNK_WIDTH || y >= CHUNK_TALL) begin
            return;
        end
        self = id_mem[x][y][z];
        if (self == ID_AIR) begin
            return;
        end
        for (d = 0; d < NDIR; d++) begin
            nx = x;
            ny = y;
            nz = z;
            case (DIR_W'(d))
                DIR_PY: ny = y + 1;
                DIR_NY: ny = y - 1;
                DIR_NX: nx = x - 1;
                DIR_PX: nx = x + 1;
                DIR_PZ: nz = z + 1;
                default: nz = z - 1;
            endcase
            if (!see_through(self, id_of(nx, ny, nz))) begin
                continue;
            end
            f = '0;
            f.fx = FXW'(x - 1);
            f.fy = YW'(y);
            f.fz = FXW'(z - 1);
            f.dir = DIR_W'(d);
            f.mat = self;
            f.lt = light_of(nx, ny, nz);
            if (f.dir == DIR_PY) begin
                t = y + 1;
                xm = id_of(x - 1, t, z);
                xp = id_of(x + 1, t, z);
                zm = id_of(x, t, z - 1);
                zp = id_of(x, t, z + 1);
                f.mm = shade(xm, zm, id_of(x - 1, t, z - 1));
                f.pm = shade(xp, zm, id_of(x + 1, t, z - 1));
                f.pp = shade(xp, zp, id_of(x + 1, t, z + 1));
                f.mp = shade(xm, zp, id_of(x - 1, t, z + 1));
            end
            found = {found, f};
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i]) begin
            pending_faces = {pending_faces, found[i]};
        end
    endtask

    // six open faces of a lone cell in air
    task automatic expect_bare(input t_cell_cmd c);
        int d;
        t_face f;
        for (d = 0; d < NDIR; d++) begin
            f = '0;
            f.fx = FXW'(c.x - 1);
            f.fy = c.y;
            f.fz = FXW'(c.z - 1);
            f.dir = DIR_W'(d);
            f.mat = c.id;
            f.lt = LIGHT_OPEN;
            f.last = (d == NDIR - 1);
            pending_faces = {pending_faces, f};
        end
    endtask

    task automatic send_cmd(input t_cell_cmd c, input t_check k);
        start <= 1'b1;
        i_operation <= c.op;
        i_cell_x <= c.x;
        i_cell_y <= c.y;
        i_cell_z <= c.z;
        i_block_id <= c.id;
        i_light_in <= c.li;
        do @(posedge i_clk); while (busy);
        if (c.op == OP_WRITE) begin
            if (c.x < SPAN && c.z < SPAN && c.y < CHUNK_TALL) begin
                id_mem[c.x][c.y][c.z] = c.id;
                light_mem[c.x][c.y][c.z] = c.li;
            end
        end else if (k == CHK_MODEL) begin
            predict_faces(c);
        end else if (k == CHK_BARE) begin
            expect_bare(c);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 16);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic idle_gap(input bit calm);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [ID_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TR_A: see_a = val;
            CFG_TR_B: see_b = val;
            CFG_TR_C: see_c = val;
            default: ;
        endcase
    endtask

    task automatic set_see_through(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                                   input logic [ID_W-1:0] c);
        cfg_write(CFG_TR_A, a);
        cfg_write(CFG_TR_B, b);
        cfg_write(CFG_TR_C, c);
        cfg_write(CFG_SPARE, ID_W'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic op, input int x, input int y, input int z,
                           input int id, input int li, input t_check k);
        t_plan_row r;
        r.cmd.op = op;
        r.cmd.x = XW'(x);
        r.cmd.y = YW'(y);
        r.cmd.z = XW'(z);
        r.cmd.id = ID_W'(id);
        r.cmd.li = LT_W'(li);
        r.chk = k;
        plan = {plan, r};
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0, 1, 2: return ID_AIR;
            3: return see_a;
            4: return see_b;
            5: return see_c;
            6: return 8'd1;
            7: return 8'd2;
            8: return 8'hFF;
            default: return ID_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_base(input int top);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic run_random(input int n_items);
        int done, wx, wy, wz, nw, nm, i;
        bit calm;
        t_cell_cmd c;
        done = 0;
        while (done < n_items) begin
            calm = ($urandom_range(0, 5) == 0);
            wx = pick_base(SPAN - 4);
            wz = pick_base(SPAN - 4);
            wy = pick_base(CHUNK_TALL - 4);
            nw = $urandom_range(4, 14);
            for (i = 0; i < nw; i++) begin
                c.op = OP_WRITE;
                c.x = XW'(wx + $urandom_range(0, 3));
                c.y = YW'(wy + $urandom_range(0, 3));
                c.z = XW'(wz + $urandom_range(0, 3));
                c.id = pick_id();
                c.li = LT_W'($urandom_range(0, 255));
                send_cmd(c, CHK_MODEL);
                idle_gap(calm);
                done++;
            end
            nm = $urandom_range(2, 6);
            for (i = 0; i < nm; i++) begin
                c.op = OP_MESH;
                c.x = XW'(wx + $urandom_range(0, 3));
                c.y = YW'(wy + $urandom_range(0, 3));
                c.z = XW'(wz + $urandom_range(0, 3));
                c.id = ID_W'($urandom_range(0, 255));
                c.li = LT_W'($urandom_range(0, 255));
                send_cmd(c, CHK_MODEL);
                idle_gap(calm);
                done++;
            end
            if ($urandom_range(0, 3) == 0) begin
                c.op = 1'($urandom_range(0, 1));
                c.x = XW'($urandom_range(0, 31));
                c.y = YW'($urandom_range(0, 127));
                c.z = XW'($urandom_range(0, 31));
                c.id = ID_W'($urandom_range(0, 255));
                c.li = LT_W'($urandom_range(0, 255));
                send_cmd(c, CHK_MODEL);
                idle_gap(calm);
                if (!(c.op == OP_WRITE && (c.x >= SPAN || c.z >= SPAN))) begin
                    done++;
                end
            end
        end
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin : face_check
        t_face got;
        t_face want;
        if (i_rst_n && o_result_valid) begin
            got = {o_face_x, o_face_y, o_face_z, o_face_dir, o_material, o_light_level,
                   o_occl_corner_mm, o_occl_corner_pm, o_occl_corner_pp, o_occl_corner_mp,
                   o_last};
            if (pending_faces.size() == 0) begin
                face_errs++;
                if (face_errs <= 10) begin
                    $display("unexpected face beat: %s", face_str(got));
                end
            end else begin
                want = pending_faces.pop_front();
                if (got !== want) begin
                    face_errs++;
                    if (face_errs <= 10) begin
                        $display("face mismatch: expected %s", face_str(want));
                        $display("               got      %s", face_str(got));
                    end
                end
            end
        end
    end

    initial begin
        int x, y, z;
        for (x = 0; x < SPAN; x++) begin
            for (y = 0; y < CHUNK_TALL; y++) begin
                for (z = 0; z < SPAN; z++) begin
                    id_mem[x][y][z] = ID_AIR;
                    light_mem[x][y][z] = LIGHT_OPEN;
                end
            end
        end
        see_a = TR_A_RST;
        see_b = TR_B_RST;
        see_c = TR_C_RST;

        add_row(OP_MESH,  1,   0,  1,   0,   0, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   0,   0, CHK_NONE);
        add_row(OP_WRITE, 8,  64,  8,   1,  10, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   1,   0, CHK_BARE);
        add_row(OP_WRITE, 8,  65,  8,   6,   0, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 9,  65,  8,   2, 200, CHK_NONE);
        add_row(OP_WRITE, 8,  65,  9,   3,   1, CHK_NONE);
        add_row(OP_WRITE, 9,  65,  9,   4, 255, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 8,  63,  8,   1,  33, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 8,  63,  8,   0,   0, CHK_NONE);
        add_row(OP_MESH,  8,  64,  8,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 1,   0,  1, 255, 255, CHK_NONE);
        add_row(OP_MESH,  1,   0,  1,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 0,   0,  1,   8,  77, CHK_NONE);
        add_row(OP_MESH,  1,   0,  1,   0,   0, CHK_MODEL);
        add_row(OP_WRITE, 16, 127, 16, 255,   0, CHK_NONE);
        add_row(OP_WRITE, 17, 127, 16,  13,   5, CHK_NONE);
        add_row(OP_MESH,  16, 127, 16, 255, 255, CHK_MODEL);
        add_row(OP_MESH,  0,   5,  5,   0,   0, CHK_NONE);
        add_row(OP_MESH,  17,  5,  5,   0,   0, CHK_NONE);
        add_row(OP_MESH,  5,   5, 31,   0,   0, CHK_NONE);
        add_row(OP_WRITE, 31, 127, 31,   9,   9, CHK_NONE);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        foreach (plan[i]) begin
            send_cmd(plan[i].cmd, plan[i].chk);
            idle_gap(1'b0);
        end
        start <= 1'b0;
        settle();

        set_see_through(8'h00, 8'h00, 8'h00);
        run_random(100);
        settle();
        set_see_through(8'hFF, 8'hFF, 8'hFF);
        run_random(100);
        settle();
        set_see_through(8'd1, 8'd2, 8'd3);
        run_random(100);
        settle();
        set_see_through(ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)),
                        ID_W'($urandom_range(0, 255)));
        run_random(100);
        settle();

        if (face_errs == 0) begin
            $display("voxel_face_cull_mesher_top_tb: PASS");
        end else begin
            $display("voxel_face_cull_mesher_top_tb: FAIL");
        end
        $finish;
    end

endmodule
